// ----- rtl/core/apr_pkg.sv -----
// ----------------------------------------------------------------------------
// apr_pkg
// Shared types and constants of the addressed packet receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package apr_pkg;

  // Frame geometry: eight bytes, position counter of three bits.
  localparam int unsigned FrameLen = 8;
  localparam int unsigned PosW     = $clog2(FrameLen);
  // Two frame slots in the buffer memory, one filling while the other drains.
  localparam int unsigned RamAw    = PosW + 1;
  localparam int unsigned RamDepth = 2 ** RamAw;

  // Byte positions inside a frame.
  localparam logic [PosW-1:0] PosDest  = 3'd0;
  localparam logic [PosW-1:0] PosSrc   = 3'd1;
  localparam logic [PosW-1:0] PosSeq   = 3'd2;
  localparam logic [PosW-1:0] PosCmd   = 3'd3;
  localparam logic [PosW-1:0] PosChan  = 3'd4;
  localparam logic [PosW-1:0] PosSize  = 3'd5;
  localparam logic [PosW-1:0] PosData  = 3'd6;
  localparam logic [PosW-1:0] PosCheck = 3'd7;

  // Command and channel codes.
  localparam logic [7:0]  CmdAck        = 8'h70;
  localparam int unsigned CmdAckReqBit  = 7;
  localparam logic [7:0]  LedChannel    = 8'h01;
  localparam logic [7:0]  OwnAddrRst    = 8'h02;

  // Output beat layout.
  localparam int unsigned OutDataW = 48;
  localparam int unsigned OutUserW = 4;

  // Drain sequencer states.
  typedef enum logic [1:0] {
    DrIdle,
    DrRead,
    DrWait,
    DrHold
  } apr_dr_state_e;

  // A completed frame handed from the framer to the drain sequencer.
  typedef struct packed {
    logic valid;
    logic slot;
    logic good;
    logic led;
  } apr_job_t;

endpackage

`default_nettype wire

// ----- rtl/core/apr_frame_ram.sv -----
// ----------------------------------------------------------------------------
// apr_frame_ram
// Frame buffer: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module apr_frame_ram (
  input  logic                    clk_i,
  input  logic                    we_i,
  input  logic [apr_pkg::RamAw-1:0] waddr_i,
  input  logic [7:0]              wdata_i,
  input  logic                    re_i,
  input  logic [apr_pkg::RamAw-1:0] raddr_i,
  output logic [7:0]              rdata_o
);
  import apr_pkg::*;

  logic [7:0] mem_q [RamDepth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/core/apr_framer.sv -----
// ----------------------------------------------------------------------------
// apr_framer
// Receive side: address matching, frame position, running checksum and LED.
// ----------------------------------------------------------------------------
`default_nettype none

module apr_framer (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [7:0]                cfg_wdata_i,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [7:0]                s_axis_tdata,
  input  logic                      s_axis_tuser,
  input  logic                      job_ready_i,
  output apr_pkg::apr_job_t         job_o,
  output logic                      ram_we_o,
  output logic [apr_pkg::RamAw-1:0] ram_waddr_o,
  output logic [7:0]                ram_wdata_o
);
  import apr_pkg::*;

  logic [7:0]      own_q;
  logic [PosW-1:0] pos_q, pos_d;
  logic            slot_q, slot_d;
  logic            led_q, led_d;
  logic [7:0]      sum_q, sum_d;
  logic            ch1_q, ch1_d;
  logic            nz_q, nz_d;
  logic            accept;
  logic            good;
  logic            led_next;

  // The closing byte waits while the drain side still holds the other slot.
  assign s_axis_tready = !((pos_q == PosCheck) && !job_ready_i);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Sum of bytes 0 to 6 is in sum_q when the checksum byte arrives.
  assign good     = (~sum_q) == s_axis_tdata;
  assign led_next = (good && ch1_q) ? (nz_q ? ~led_q : 1'b0) : led_q;

  always_comb begin
    pos_d       = pos_q;
    slot_d      = slot_q;
    led_d       = led_q;
    sum_d       = sum_q;
    ch1_d       = ch1_q;
    nz_d        = nz_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = {slot_q, pos_q};
    ram_wdata_o = s_axis_tdata;
    job_o.valid = 1'b0;
    job_o.slot  = slot_q;
    job_o.good  = good;
    job_o.led   = led_next;
    if (accept) begin
      if (s_axis_tuser) begin
        pos_d = PosDest;
        if (s_axis_tdata == own_q) begin
          ram_we_o    = 1'b1;
          ram_waddr_o = {slot_q, PosDest};
          sum_d       = s_axis_tdata;
          pos_d       = PosSrc;
        end
      end else if (pos_q != PosDest) begin
        ram_we_o = 1'b1;
        sum_d    = sum_q + s_axis_tdata;
        if (pos_q == PosChan) begin
          ch1_d = s_axis_tdata == LedChannel;
        end
        if (pos_q == PosData) begin
          nz_d = s_axis_tdata != 8'h00;
        end
        if (pos_q == PosCheck) begin
          job_o.valid = 1'b1;
          led_d       = led_next;
          slot_d      = ~slot_q;
          pos_d       = PosDest;
        end else begin
          pos_d = pos_q + PosW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_q  <= OwnAddrRst;
      pos_q  <= PosDest;
      slot_q <= 1'b0;
      led_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        own_q <= cfg_wdata_i;
      end
      pos_q  <= pos_d;
      slot_q <= slot_d;
      led_q  <= led_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
    ch1_q <= ch1_d;
    nz_q  <= nz_d;
  end

endmodule

`default_nettype wire

// ----- rtl/core/apr_drain.sv -----
// ----------------------------------------------------------------------------
// apr_drain
// Drain sequencer: reads a finished frame slot byte by byte and builds the
// output beat in a register of its own.
// ----------------------------------------------------------------------------
`default_nettype none

module apr_drain (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  apr_pkg::apr_job_t             job_i,
  output logic                          job_ready_o,
  output logic                          ram_re_o,
  output logic [apr_pkg::RamAw-1:0]     ram_raddr_o,
  input  logic [7:0]                    ram_rdata_i,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [apr_pkg::OutDataW-1:0]  m_axis_tdata,
  output logic [apr_pkg::OutUserW-1:0]  m_axis_tuser
);
  import apr_pkg::*;

  apr_dr_state_e state_q, state_d;
  logic [PosW-1:0] idx_q;
  logic [PosW-1:0] rd_tag_q;
  logic            rd_vld_q;
  logic            slot_q, good_q, led_q;
  logic [7:0]      src_q, seq_q, cmd_q, chan_q, size_q, pay_q;
  logic            out_valid_q;
  logic [OutDataW-1:0] out_data_q;
  logic [OutUserW-1:0] out_user_q;
  logic            out_free;
  logic            out_load;
  logic            job_take;

  assign out_free = !out_valid_q || m_axis_tready;
  assign job_take = job_i.valid && job_ready_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      DrIdle: begin
        if (job_i.valid) begin
          state_d = DrRead;
        end
      end
      DrRead: begin
        if (idx_q == PosData) begin
          state_d = DrWait;
        end
      end
      DrWait: begin
        state_d = DrHold;
      end
      DrHold: begin
        if (out_free) begin
          state_d = job_i.valid ? DrRead : DrIdle;
        end
      end
      default: begin
        state_d = DrIdle;
      end
    endcase
  end

  // A new frame may be taken in the same cycle as the finished beat moves out.
  always_comb begin
    job_ready_o = (state_q == DrIdle) || ((state_q == DrHold) && out_free);
    ram_re_o    = state_q == DrRead;
    ram_raddr_o = {slot_q, idx_q};
    out_load    = (state_q == DrHold) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= DrIdle;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= ram_re_o;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_take) begin
      slot_q <= job_i.slot;
      good_q <= job_i.good;
      led_q  <= job_i.led;
      idx_q  <= PosSrc;
    end else if (state_q == DrRead) begin
      idx_q <= idx_q + PosW'(1);
    end
    rd_tag_q <= idx_q;
    if (rd_vld_q) begin
      unique case (rd_tag_q)
        PosSrc:  src_q  <= ram_rdata_i;
        PosSeq:  seq_q  <= ram_rdata_i;
        PosCmd:  cmd_q  <= ram_rdata_i;
        PosChan: chan_q <= ram_rdata_i;
        PosSize: size_q <= ram_rdata_i;
        PosData: pay_q  <= ram_rdata_i;
        default: ;
      endcase
    end
    if (out_load) begin
      out_data_q <= {pay_q, size_q, chan_q, cmd_q, seq_q, src_q};
      out_user_q <= {led_q, cmd_q == CmdAck, cmd_q[CmdAckReqBit], good_q};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

`default_nettype wire

// ----- rtl/core/addressed_packet_receiver.sv -----
// ----------------------------------------------------------------------------
// addressed_packet_receiver
// Nine-bit address-mark packet receiver with checksum check and LED control.
// ----------------------------------------------------------------------------
// The receiver takes one character beat per clock while s_axis_tready is high:
// the data byte on s_axis_tdata and the address mark on s_axis_tuser. Bytes of
// an open frame are written into a two-slot frame buffer memory while a running
// checksum, the channel test and the LED state are kept in registers. When the
// eighth byte arrives the filled slot is handed to a drain sequencer, which
// reads the six reported bytes through the single read port and places one
// packet beat in the output register once it is free; meanwhile the next frame
// fills the other slot. A frame costs at least eight input beats, so frames can
// follow back to back, and a checksum byte is only held back while the previous
// packet is still being read out or is waiting for the output register to
// empty. The own address resets to 2; it must be written through cfg_we_i and
// cfg_wdata_i only while the block is idle, which the block does not enforce.
// ----------------------------------------------------------------------------
`default_nettype none

module addressed_packet_receiver (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,    // own_address
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic        s_axis_tuser,   // [0] address_mark
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] source_address, [15:8] sequence_number, [23:16] command_byte,
  // [31:24] channel_number, [39:32] size_byte, [47:40] payload_byte
  output logic [47:0] m_axis_tdata,
  // [0] checksum_ok, [1] ack_requested, [2] is_acknowledge, [3] led_on
  output logic [3:0]  m_axis_tuser
);
  import apr_pkg::*;

  apr_job_t         job;
  logic             job_ready;
  logic             ram_we;
  logic [RamAw-1:0] ram_waddr;
  logic [7:0]       ram_wdata;
  logic             ram_re;
  logic [RamAw-1:0] ram_raddr;
  logic [7:0]       ram_rdata;

  apr_framer u_framer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .job_ready_i   (job_ready),
    .job_o         (job),
    .ram_we_o      (ram_we),
    .ram_waddr_o   (ram_waddr),
    .ram_wdata_o   (ram_wdata)
  );

  apr_frame_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  apr_drain u_drain (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_i         (job),
    .job_ready_o   (job_ready),
    .ram_re_o      (ram_re),
    .ram_raddr_o   (ram_raddr),
    .ram_rdata_i   (ram_rdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

`default_nettype wire

// ----- rtl/core/apr_checker.sv -----
// ----------------------------------------------------------------------------
// apr_checker
// Port-level checks of the addressed packet receiver, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module apr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic [3:0]  m_axis_tuser
);
  import apr_pkg::*;

  // A stalled packet beat keeps its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("packet beat changed while stalled");

  // The acknowledgment request flag follows bit 7 of the command byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser[1] == m_axis_tdata[23])
    else $error("ack request flag does not match command byte");

  // The acknowledgment flag is set for the acknowledgment command only.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser[2] == (m_axis_tdata[23:16] == CmdAck))
    else $error("acknowledgment flag does not match command byte");

  // No packet is on offer as reset is released.
  assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("packet beat offered out of reset");

endmodule

bind addressed_packet_receiver apr_checker u_apr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
